/* rtl/wrp_pkg.sv */
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants of the WAV RIFF header parser: result item,
// packed stream word, push group between core and result queue, tags.
// ----------------------------------------------------------------------------
package wrp_pkg;

	typedef enum logic [1:0] {
		KIND_FORMAT = 2'd0,
		KIND_AUDIO  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_NOT_RIFF    = 4'd1,
		ST_NO_WAVE     = 4'd2,
		ST_NO_FMT      = 4'd3,
		ST_NO_DATA     = 4'd4,
		ST_BAD_SIZE    = 4'd5,
		ST_SHORT_FMT   = 4'd6,
		ST_DATA_EARLY  = 4'd7,
		ST_NOT_PCM     = 4'd8,
		ST_BAD_CHANS   = 4'd9,
		ST_BAD_BITS    = 4'd10,
		ST_EMPTY_DATA  = 4'd11,
		ST_SHORT_AUDIO = 4'd12
	} status_t;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [31:0] FMT_LEN  = 32'd16;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [1:0]  channels;
		logic [31:0] sample_rate;
		logic [4:0]  bits_per_sample;
		logic [30:0] data_size;
		logic [7:0]  audio_byte;
		logic        audio_last;
		logic        run_last;
	} result_t;

	// Stream word on m_tdata; first member is the top bits.
	typedef struct packed {
		logic [4:0]  pad;
		logic        run_last;
		logic [7:0]  audio_byte;
		logic [30:0] data_size;
		logic [4:0]  bits_per_sample;
		logic [31:0] sample_rate;
		logic [1:0]  channels;
		status_t     status;
	} tdata_t;

	localparam int TDATA_W = $bits(tdata_t);

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

/* rtl/wrp_parse_core.sv */
// ----------------------------------------------------------------------------
// wrp_parse_core
// Parser state and per-byte update: tag and size shifting, chunk walk,
// fmt capture, skip and audio pass-through; yields up to two results.
// ----------------------------------------------------------------------------
module wrp_parse_core
	import wrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       end_of_file,
	output push_t      push
);

	typedef enum logic [3:0] {
		PH_RIFF   = 4'd0,
		PH_RSIZE  = 4'd1,
		PH_WAVE   = 4'd2,
		PH_CID    = 4'd3,
		PH_CSIZE  = 4'd4,
		PH_FMT    = 4'd5,
		PH_SKIP   = 4'd6,
		PH_AUDIO  = 4'd7,
		PH_DONE   = 4'd8,
		PH_IGNORE = 4'd9
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  byte_index;
		logic [31:0] tag_shift;
		logic [31:0] size_shift;
		logic [31:0] bytes_left;
		logic        pad_pending;
		logic        have_format;
		logic [15:0] audio_format_code;
		logic [15:0] channel_count;
		logic [31:0] rate_value;
		logic [15:0] sample_bits;
	} state_t;

	state_t      st_q;
	state_t      st_d;
	result_t     res_a;
	result_t     res_b;
	logic [1:0]  nres;
	logic [31:0] chunk_size;
	logic        eof_err;
	status_t     eof_code;
	status_t     fail_code;
	logic        fail;
	logic        audio_end;

	function automatic result_t make_error(input status_t code);
		result_t r;
		r        = '0;
		r.kind   = KIND_ERROR;
		r.status = code;
		return r;
	endfunction

	always_comb begin
		st_d       = st_q;
		res_a      = '0;
		res_b      = '0;
		nres       = 2'd0;
		chunk_size = '0;
		eof_err    = 1'b0;
		eof_code   = ST_OK;
		fail       = 1'b0;
		fail_code  = ST_OK;
		audio_end  = 1'b0;

		unique case (st_q.phase)
			PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE: begin
				if (st_q.phase == PH_CSIZE) begin
					st_d.size_shift = {data_byte, st_q.size_shift[31:8]};
				end else begin
					st_d.tag_shift = {data_byte, st_q.tag_shift[31:8]};
				end
				st_d.byte_index = st_q.byte_index + 4'd1;
				if (st_d.byte_index == 4'd4) begin
					st_d.byte_index = '0;
					chunk_size      = st_d.size_shift;
					priority if (st_q.phase == PH_RIFF) begin
						if (st_d.tag_shift != TAG_RIFF) begin
							fail      = 1'b1;
							fail_code = ST_NOT_RIFF;
						end else begin
							st_d.phase = PH_RSIZE;
						end
					end else if (st_q.phase == PH_RSIZE) begin
						st_d.phase = PH_WAVE;
					end else if (st_q.phase == PH_WAVE) begin
						if (st_d.tag_shift != TAG_WAVE) begin
							fail      = 1'b1;
							fail_code = ST_NO_WAVE;
						end else begin
							st_d.phase = PH_CID;
						end
					end else if (st_q.phase == PH_CID) begin
						st_d.phase = PH_CSIZE;
					end else begin
						// chunk header complete
						priority if (chunk_size[31]) begin
							fail      = 1'b1;
							fail_code = ST_BAD_SIZE;
						end else if (st_q.tag_shift == TAG_FMT) begin
							if (chunk_size < FMT_LEN) begin
								fail      = 1'b1;
								fail_code = ST_SHORT_FMT;
							end else begin
								st_d.phase       = PH_FMT;
								st_d.byte_index  = '0;
								st_d.bytes_left  = chunk_size - FMT_LEN;
								st_d.pad_pending = chunk_size[0];
							end
						end else if (st_q.tag_shift == TAG_DATA) begin
							priority if (!st_q.have_format) begin
								fail      = 1'b1;
								fail_code = ST_DATA_EARLY;
							end else if (st_q.audio_format_code != 16'd1) begin
								fail      = 1'b1;
								fail_code = ST_NOT_PCM;
							end else if (st_q.channel_count != 16'd1 &&
								st_q.channel_count != 16'd2) begin
								fail      = 1'b1;
								fail_code = ST_BAD_CHANS;
							end else if (st_q.sample_bits != 16'd8 &&
								st_q.sample_bits != 16'd16) begin
								fail      = 1'b1;
								fail_code = ST_BAD_BITS;
							end else if (chunk_size == 32'd0) begin
								fail      = 1'b1;
								fail_code = ST_EMPTY_DATA;
							end else begin
								res_a.kind            = KIND_FORMAT;
								res_a.status          = ST_OK;
								res_a.channels        = st_q.channel_count[1:0];
								res_a.sample_rate     = st_q.rate_value;
								res_a.bits_per_sample = st_q.sample_bits[4:0];
								res_a.data_size       = chunk_size[30:0];
								nres                  = 2'd1;
								st_d.bytes_left       = chunk_size;
								st_d.phase            = PH_AUDIO;
							end
						end else begin
							st_d.bytes_left  = chunk_size;
							st_d.pad_pending = chunk_size[0];
							st_d.phase       = (chunk_size == 32'd0) ? PH_CID : PH_SKIP;
						end
					end
				end
			end
			PH_FMT: begin
				unique case (st_q.byte_index)
					4'd0:  st_d.audio_format_code = {8'h00, data_byte};
					4'd1:  st_d.audio_format_code[15:8] = data_byte;
					4'd2:  st_d.channel_count = {8'h00, data_byte};
					4'd3:  st_d.channel_count[15:8] = data_byte;
					4'd4:  st_d.rate_value = {24'h00_0000, data_byte};
					4'd5:  st_d.rate_value[15:8] = data_byte;
					4'd6:  st_d.rate_value[23:16] = data_byte;
					4'd7:  st_d.rate_value[31:24] = data_byte;
					4'd14: st_d.sample_bits = {8'h00, data_byte};
					4'd15: st_d.sample_bits[15:8] = data_byte;
					default: ;
				endcase
				if (st_q.byte_index == 4'd15) begin
					st_d.byte_index  = '0;
					st_d.have_format = 1'b1;
					st_d.phase = (st_q.bytes_left != 32'd0 || st_q.pad_pending) ?
						PH_SKIP : PH_CID;
				end else begin
					st_d.byte_index = st_q.byte_index + 4'd1;
				end
			end
			PH_SKIP: begin
				if (st_q.bytes_left != 32'd0) begin
					st_d.bytes_left = st_q.bytes_left - 32'd1;
				end else begin
					st_d.pad_pending = 1'b0;
				end
				if (st_d.bytes_left == 32'd0 && !st_d.pad_pending) begin
					st_d.phase      = PH_CID;
					st_d.byte_index = '0;
				end
			end
			PH_AUDIO: begin
				audio_end        = (st_q.bytes_left <= 32'd1);
				res_a.kind       = KIND_AUDIO;
				res_a.status     = ST_OK;
				res_a.audio_byte = data_byte;
				res_a.audio_last = audio_end;
				nres             = 2'd1;
				if (st_q.bytes_left != 32'd0) begin
					st_d.bytes_left = st_q.bytes_left - 32'd1;
				end
				if (audio_end) begin
					st_d.phase = PH_DONE;
				end
			end
			PH_DONE, PH_IGNORE: ;
			default: ;
		endcase

		if (fail) begin
			res_a      = make_error(fail_code);
			nres       = 2'd1;
			st_d.phase = PH_IGNORE;
		end

		// end of file: report by the phase reached, then restart
		if (end_of_file) begin
			eof_err = 1'b1;
			unique case (st_d.phase)
				PH_RIFF:                     eof_code = ST_NOT_RIFF;
				PH_RSIZE, PH_WAVE:           eof_code = ST_NO_WAVE;
				PH_CID, PH_CSIZE, PH_SKIP:
					eof_code = st_d.have_format ? ST_NO_DATA : ST_NO_FMT;
				PH_FMT:                      eof_code = ST_SHORT_FMT;
				PH_AUDIO:                    eof_code = ST_SHORT_AUDIO;
				default:                     eof_err  = 1'b0;
			endcase
			if (eof_err) begin
				if (nres == 2'd0) begin
					res_a = make_error(eof_code);
					nres  = 2'd1;
				end else begin
					res_b = make_error(eof_code);
					nres  = 2'd2;
				end
			end
			st_d = '0;
		end

		if (nres == 2'd1) begin
			res_a.run_last = 1'b1;
		end
		if (nres == 2'd2) begin
			res_b.run_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	assign push.count  = nres;
	assign push.first  = res_a;
	assign push.second = res_b;

endmodule

/* rtl/wrp_result_queue.sv */
// ----------------------------------------------------------------------------
// wrp_result_queue
// Small result queue: takes up to two results per cycle, gives one per
// handshake, and flags room for a full push.
// ----------------------------------------------------------------------------
module wrp_result_queue
	import wrp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_en,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t head
);

	localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	result_t            mem [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W-1:0]   wr_next;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         n_push;
	logic               pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign wr_next   = next_ptr(wr_q);
	assign n_push    = push_en ? push.count : 2'd0;
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= CNT_W'(DEPTH - 2));
	assign head      = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			unique case (n_push)
				2'd1:    wr_q <= wr_next;
				2'd2:    wr_q <= next_ptr(wr_next);
				default: ;
			endcase
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (n_push == 2'd2) begin
			mem[wr_next] <= push.second;
		end
	end

endmodule

/* rtl/wav_riff_header_parser.sv */
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// Byte-stream WAV parser: checks RIFF/WAVE, walks chunks, captures the PCM
// format, then passes the audio bytes through with format and error items.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                 | tuser       | tlast
//  --------+-----+-----------------------+-------------+------------------
//  s_      | in  | data_byte [7:0]       | -           | end_of_file
//  m_      | out | see tdata_t, 88 bits  | result_kind | audio_last
//
//  One input byte per cycle while s_tready is high: the parser state updates in
//  a single pass of logic, and its results enter the result queue at the
//  accepting edge, so the first of them can be offered on m_ right after it.
//  A byte causes at most two results; with m_tready high the queue drains one
//  per cycle, so bytes that cause at most one result sustain one byte per cycle.
//  s_tready drops while the queue has fewer than two free places.
//  arst_n clears parser state and empties the queue; no clearing pass.
//  End of file returns the parser to its reset state after its results.
//
module wav_riff_header_parser
	import wrp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] data_byte
	input  logic               s_tlast,   // end_of_file
	output logic               m_tvalid,
	input  logic               m_tready,
	// [3:0] status, [5:4] channels, [37:6] sample_rate, [42:38] bits_per_sample,
	// [73:43] data_size, [81:74] audio_byte, [82] run_last, [87:83] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic [1:0]         m_tuser,   // [1:0] result_kind
	output logic               m_tlast    // audio_last
);

	logic    accept;
	logic    room;
	push_t   push;
	result_t head;
	tdata_t  word;

	// take a byte only when a full two-result push fits
	assign s_tready = room;
	assign accept   = s_tvalid && s_tready;

	wrp_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.data_byte   (s_tdata),
		.end_of_file (s_tlast),
		.push        (push)
	);

	wrp_result_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (accept),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.head      (head)
	);

	// pack the head result onto the stream word
	always_comb begin
		word                 = '0;
		word.status          = head.status;
		word.channels        = head.channels;
		word.sample_rate     = head.sample_rate;
		word.bits_per_sample = head.bits_per_sample;
		word.data_size       = head.data_size;
		word.audio_byte      = head.audio_byte;
		word.run_last        = head.run_last;
	end

	assign m_tdata = word;
	assign m_tuser = head.kind;
	assign m_tlast = head.audio_last;

endmodule

/* rtl/wrp_checker.sv */
// ----------------------------------------------------------------------------
// wrp_checker
// Port-level checks of the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module wrp_checker
	import wrp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [1:0]         m_tuser,
	input logic               m_tlast
);

	tdata_t word;
	assign word = m_tdata;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_last_audio: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == KIND_AUDIO)
		else $error("audio_last on a non-audio item");

	a_error_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ERROR |-> word.status != ST_OK && word.run_last)
		else $error("error item without code or not last of its run");

	a_format_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_FORMAT |-> word.status == ST_OK &&
		word.channels != 2'd0 && word.data_size != 31'd0 &&
		(word.bits_per_sample == 5'd8 || word.bits_per_sample == 5'd16))
		else $error("format item out of range");

endmodule

bind wav_riff_header_parser wrp_checker u_wrp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
